FILE: sv/sma_pkg.sv
// Shared field widths, order side codes and the result beat type for the
// moving average signal block. No dependencies.
package sma_pkg;

  localparam int SYM_IN_W = 4;
  localparam int PRICE_W  = 32;
  localparam int TDATA_W  = 40;
  localparam int SYM_SPAN = 1 << SYM_IN_W;

  typedef enum logic {
    SIDE_BUY  = 1'b0,
    SIDE_SELL = 1'b1
  } order_side_t;

  typedef struct packed {
    logic [SYM_IN_W-1:0] symbol;
    order_side_t         side;
    logic [PRICE_W-1:0]  price;
  } order_t;

endpackage

FILE: sv/sma_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read (old data on a same-address collision). No dependencies.
module sma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

FILE: sv/sma_update.sv
// Per-symbol update pipeline: symbol state memory, price window memory,
// forwarding and the mean compare. Depends on sma_pkg and sma_ram.
module sma_update
  import sma_pkg::*;
#(
  parameter int NUM_SYMBOLS = 16,
  parameter int WINDOW      = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en_i,
  input  logic                in_valid_i,
  input  logic [SYM_IN_W-1:0] in_sym_i,
  input  logic [PRICE_W-1:0]  in_price_i,
  output logic                res_valid_o,
  output order_t              res_o
);

  localparam int SYM_DEPTH  = (NUM_SYMBOLS < SYM_SPAN) ? NUM_SYMBOLS : SYM_SPAN;
  localparam int SYM_W      = (SYM_DEPTH > 1) ? $clog2(SYM_DEPTH) : 1;
  localparam int FILL_W     = $clog2(WINDOW + 1);
  localparam int SLOT_W     = $clog2(WINDOW);
  localparam int SLOT_SUM_W = SLOT_W + 1;
  localparam int SUM_W      = PRICE_W + $clog2(WINDOW);
  localparam int WIN_DEPTH  = SYM_DEPTH * WINDOW;
  localparam int WIN_AW     = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
  localparam int ST_W       = FILL_W + SLOT_W + SUM_W;

  typedef struct packed {
    logic [FILL_W-1:0] fill;
    logic [SLOT_W-1:0] oldest;
    logic [SUM_W-1:0]  sum;
  } sym_state_t;

  // intake
  logic             in_range;
  logic [SYM_W-1:0] in_idx;

  // stage 1: state read back
  logic                s1_valid_r;
  logic [SYM_IN_W-1:0] s1_sym_r;
  logic [PRICE_W-1:0]  s1_price_r;
  logic                s1_sval_r;
  logic [SYM_W-1:0]    s1_idx;
  sym_state_t          cur;
  logic                filling;
  logic [SLOT_SUM_W-1:0] fill_sum;
  logic [SLOT_SUM_W-1:0] evict_inc;
  logic [SLOT_W-1:0]   fill_slot;
  logic [SLOT_W-1:0]   evict_slot;
  logic [SLOT_W-1:0]   slot;
  logic [SLOT_W-1:0]   new_oldest;
  logic [FILL_W-1:0]   new_fill;
  logic [WIN_AW-1:0]   win_addr;
  logic [SUM_W-1:0]    scaled;

  // stage 2: old price back, sum update
  logic                s2_valid_r;
  logic [SYM_IN_W-1:0] s2_sym_r;
  logic [PRICE_W-1:0]  s2_price_r;
  logic [FILL_W-1:0]   s2_fill_r;
  logic [SLOT_W-1:0]   s2_oldest_r;
  logic [SUM_W-1:0]    s2_sum_r;
  logic                s2_sub_r;
  logic [SUM_W-1:0]    s2_scaled_r;
  logic [SYM_W-1:0]    s2_idx;
  logic [PRICE_W-1:0]  old_price;
  logic [SUM_W-1:0]    sum_new;
  sym_state_t          wr_state;

  // last write, for a read issued at the same edge
  logic                w_valid_r;
  logic [SYM_W-1:0]    w_idx_r;
  sym_state_t          w_state_r;

  // stage 3: compare
  logic                s3_valid_r;
  logic [SYM_IN_W-1:0] s3_sym_r;
  logic [PRICE_W-1:0]  s3_price_r;
  logic [SUM_W-1:0]    s3_sum_r;
  logic [SUM_W-1:0]    s3_scaled_r;
  logic                s3_full_r;

  logic [SYM_DEPTH-1:0] sval_r;
  logic [ST_W-1:0]      st_rdata;

  assign in_range = ({{(32 - SYM_IN_W){1'b0}}, in_sym_i} < 32'(NUM_SYMBOLS));
  assign in_idx   = in_sym_i[SYM_W-1:0];
  assign s1_idx   = s1_sym_r[SYM_W-1:0];
  assign s2_idx   = s2_sym_r[SYM_W-1:0];

  sma_ram #(.WIDTH(ST_W), .DEPTH(SYM_DEPTH), .AW(SYM_W)) u_state_ram (
    .clk   (clk),
    .we    (en_i && s2_valid_r),
    .waddr (s2_idx),
    .wdata (wr_state),
    .re    (en_i),
    .raddr (in_idx),
    .rdata (st_rdata)
  );

  // read the evicted price and replace it in the same cycle
  sma_ram #(.WIDTH(PRICE_W), .DEPTH(WIN_DEPTH), .AW(WIN_AW)) u_window_ram (
    .clk   (clk),
    .we    (en_i && s1_valid_r),
    .waddr (win_addr),
    .wdata (s1_price_r),
    .re    (en_i),
    .raddr (win_addr),
    .rdata (old_price)
  );

  // forward the newest state of this symbol
  always_comb begin
    if (s2_valid_r && (s2_idx == s1_idx)) begin
      cur = wr_state;
    end else if (w_valid_r && (w_idx_r == s1_idx)) begin
      cur = w_state_r;
    end else if (s1_sval_r) begin
      cur = sym_state_t'(st_rdata);
    end else begin
      cur = '0;
    end
  end

  always_comb begin
    filling   = (cur.fill < FILL_W'(WINDOW));
    fill_sum  = SLOT_SUM_W'(cur.oldest) + SLOT_SUM_W'(cur.fill[SLOT_W-1:0]);
    if (fill_sum >= SLOT_SUM_W'(WINDOW)) begin
      fill_slot = SLOT_W'(fill_sum - SLOT_SUM_W'(WINDOW));
    end else begin
      fill_slot = fill_sum[SLOT_W-1:0];
    end
    if (SLOT_SUM_W'(cur.oldest) >= SLOT_SUM_W'(WINDOW)) begin
      evict_slot = '0;
    end else begin
      evict_slot = cur.oldest;
    end
    evict_inc = SLOT_SUM_W'(evict_slot) + SLOT_SUM_W'(1);
    if (filling) begin
      slot       = fill_slot;
      new_oldest = cur.oldest;
      new_fill   = cur.fill + FILL_W'(1);
    end else begin
      slot       = evict_slot;
      new_oldest = (evict_inc == SLOT_SUM_W'(WINDOW)) ? '0 : evict_inc[SLOT_W-1:0];
      new_fill   = cur.fill;
    end
    win_addr = WIN_AW'(s1_idx) * WIN_AW'(WINDOW) + WIN_AW'(slot);
    scaled   = SUM_W'(s1_price_r) * SUM_W'(WINDOW);
  end

  always_comb begin
    sum_new = s2_sum_r - (s2_sub_r ? SUM_W'(old_price) : SUM_W'(0)) + SUM_W'(s2_price_r);
    wr_state.fill   = s2_fill_r;
    wr_state.oldest = s2_oldest_r;
    wr_state.sum    = sum_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      w_valid_r  <= 1'b0;
      sval_r     <= '0;
    end else if (en_i) begin
      s1_valid_r <= in_valid_i && in_range;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      w_valid_r  <= s2_valid_r;
      if (s2_valid_r) begin
        sval_r[s2_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      s1_sym_r    <= in_sym_i;
      s1_price_r  <= in_price_i;
      s1_sval_r   <= sval_r[in_idx];
      s2_sym_r    <= s1_sym_r;
      s2_price_r  <= s1_price_r;
      s2_fill_r   <= new_fill;
      s2_oldest_r <= new_oldest;
      s2_sum_r    <= cur.sum;
      s2_sub_r    <= !filling;
      s2_scaled_r <= scaled;
      w_idx_r     <= s2_idx;
      w_state_r   <= wr_state;
      s3_sym_r    <= s2_sym_r;
      s3_price_r  <= s2_price_r;
      s3_sum_r    <= sum_new;
      s3_scaled_r <= s2_scaled_r;
      s3_full_r   <= (s2_fill_r == FILL_W'(WINDOW));
    end
  end

  assign res_valid_o  = en_i && s3_valid_r && s3_full_r && (s3_scaled_r != s3_sum_r);
  assign res_o.symbol = s3_sym_r;
  assign res_o.side   = (s3_scaled_r > s3_sum_r) ? SIDE_BUY : SIDE_SELL;
  assign res_o.price  = s3_price_r;

  a_evict_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && s2_sub_r |-> s2_fill_r == FILL_W'(WINDOW))
    else $error("eviction with a window that is not full");

  a_oldest_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> SLOT_SUM_W'(s2_oldest_r) < SLOT_SUM_W'(WINDOW))
    else $error("oldest slot beyond window");

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    !en_i |=> $stable(s1_valid_r) && $stable(s2_valid_r) && $stable(s3_valid_r))
    else $error("pipeline moved during stall");

endmodule

FILE: sv/sma_out_skid.sv
// Output register with a one-entry skid stage for result beats.
// Depends on sma_pkg.
module sma_out_skid
  import sma_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push_i,
  input  order_t push_data_i,
  output logic   full_o,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output order_t out_data_o
);

  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   skid_valid_r;
  logic   skid_valid_nxt;
  order_t out_data_r;
  order_t out_data_nxt;
  order_t skid_data_r;
  order_t skid_data_nxt;
  logic   pop;

  assign pop = out_valid_r && out_ready_i;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_r || pop) begin
        out_data_nxt  = push_data_i;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = push_data_i;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign full_o      = skid_valid_r;
  assign out_valid_o = out_valid_r;
  assign out_data_o  = out_data_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a beat while output is empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> !skid_valid_r)
    else $error("result pushed into a full output stage");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && pop |=> out_valid_r && !skid_valid_r)
    else $error("skid beat not moved to output");

endmodule

FILE: sv/moving_average_trade_signal_top.sv
// Top level of the moving average crossover signal block.
// Depends on sma_pkg, sma_update, sma_out_skid (and sma_ram below them).
//
// Takes one price beat per clock while ready (symbol index, price in ticks)
// and keeps, per symbol, the last WINDOW prices, a fill count and a running
// sum. Once a symbol's window is full, each new price is compared with the
// window mean (price * WINDOW against the sum) and a buy order (tuser 0)
// leaves when the price is above the mean, a sell order (tuser 1) when it is
// below; equal prices and filling windows produce no beat. Symbol indexes at
// or beyond NUM_SYMBOLS are dropped without touching state. Throughput is one
// beat per cycle while in_tready is high. Each beat passes the three-stage
// pipeline (read-modify-write through the per-symbol state memory and the
// price window memory, then the compare) and the output register, with
// forwarding between beats of the same symbol. The output side holds up to
// two results, so in_tready depends only on registered state and drops only
// when both are occupied.
// Per-symbol state is cleared at reset through valid flags; there is no
// memory clearing pass and the block is ready from the first cycle.
module moving_average_trade_signal_top
  import sma_pkg::*;
#(
  parameter int NUM_SYMBOLS = 16,
  parameter int WINDOW      = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,   // [3:0] symbol_index, [35:4] price, zero pad
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,  // [3:0] order_symbol, [35:4] order_price, zero pad
  output logic [0:0]         out_tuser   // [0] order_side
);

  logic   stall;
  logic   res_valid;
  order_t res;
  order_t out_beat;

  // hold the whole pipeline while both output slots are taken
  assign in_tready = !stall;

  sma_update #(
    .NUM_SYMBOLS (NUM_SYMBOLS),
    .WINDOW      (WINDOW)
  ) u_update (
    .clk         (clk),
    .rst_n       (rst_n),
    .en_i        (!stall),
    .in_valid_i  (in_tvalid),
    .in_sym_i    (in_tdata[SYM_IN_W-1:0]),
    .in_price_i  (in_tdata[SYM_IN_W +: PRICE_W]),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  sma_out_skid u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (stall),
    .out_valid_o (out_tvalid),
    .out_ready_i (out_tready),
    .out_data_o  (out_beat)
  );

  // pack the result beat: symbol low, price above, zero fill to whole bytes
  assign out_tdata = {{(TDATA_W - SYM_IN_W - PRICE_W){1'b0}}, out_beat.price, out_beat.symbol};
  assign out_tuser = out_beat.side;

endmodule
